// File: hdl/text_char_renderer_macros.svh
// assertion macros for the text character renderer
// used by the top level only, clock clk and reset rst_n taken from the including scope
`ifndef TEXT_CHAR_RENDERER_MACROS_SVH
`define TEXT_CHAR_RENDERER_MACROS_SVH

// same-cycle implication
`define TCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/trc_pkg.sv
// shared types, constants and the 8x16 font rom of the text character renderer
// no dependencies
`default_nettype none

package trc_pkg;

  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned GLYPH_H = 16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [3:0] ROW_LAST   = 4'(GLYPH_H - 1);

  // placement decision for one accepted item
  typedef struct packed {
    logic       keep;
    logic [7:0] x;
    logic [7:0] y;
    logic [6:0] ch;
  } place_t;

  // whole glyph, row 0 in the top byte
  function automatic logic [127:0] glyph_bits(input logic [6:0] ch);
    logic [127:0] g;
    case (ch)
      7'h25:   g = 128'h0000464c_3a32160c_18342c5c_62000000; // percent
      7'h2d:   g = 128'h00000000_0000003e_00000000_00000000; // minus
      7'h2e:   g = 128'h00000000_00000000_00000000_0c0c0000; // period
      7'h30:   g = 128'h00001c22_42424242_42424222_1c000000;
      7'h31:   g = 128'h0000081c_08080808_08080808_1c000000;
      7'h32:   g = 128'h00001c22_42020204_08102042_7e000000;
      7'h33:   g = 128'h00001c22_4202021c_02024222_1c000000;
      7'h34:   g = 128'h0000040c_14244444_7e040404_1e000000;
      7'h35:   g = 128'h00007e40_40407c02_02024222_1c000000;
      7'h36:   g = 128'h00001c22_40407c42_42424222_1c000000;
      7'h37:   g = 128'h00007e42_02020404_08081010_10000000;
      7'h38:   g = 128'h00001c22_42221c22_42424222_1c000000;
      7'h39:   g = 128'h00001c22_4242423e_02024222_1c000000;
      7'h3a:   g = 128'h00000000_0c0c0000_00000c0c_00000000; // colon
      7'h41:   g = 128'h00001018_28284444_7c444444_44000000;
      7'h42:   g = 128'h00007c22_22223c22_22222222_7c000000;
      7'h43:   g = 128'h00003c42_42404040_40404242_3c000000;
      7'h4d:   g = 128'h00004262_72524a4a_42424242_42000000;
      7'h50:   g = 128'h00007c22_22223c40_40404040_40000000;
      7'h52:   g = 128'h00007c22_22223c28_24444444_44000000;
      7'h53:   g = 128'h00003c42_42403c02_02024222_1c000000;
      7'h54:   g = 128'h00007e18_18181818_18181818_18000000;
      7'h57:   g = 128'h00004242_42424a4a_52526222_22000000;
      default: g = 128'h0;
    endcase
    return g;
  endfunction

  // one font row, bit 7 is the leftmost pixel
  function automatic logic [7:0] font_row(input logic [6:0] ch, input logic [3:0] row);
    logic [127:0] g;
    g = glyph_bits(ch);
    return g[{~row, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: hdl/trc_cursor.sv
// cursor, wrap and bottom-edge logic of the text character renderer
// depends on trc_pkg
`default_nettype none

module trc_cursor import trc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 160
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       new_string,
  input  wire logic [7:0] start_x,
  input  wire logic [7:0] start_y,
  output place_t          place
);

  localparam logic [9:0] WIDTH_LIM  = 10'(SCREEN_WIDTH);
  localparam logic [9:0] HEIGHT_LIM = 10'(SCREEN_HEIGHT);

  logic [8:0] cursor_x_r, cursor_x_nxt;
  logic [8:0] cursor_y_r, cursor_y_nxt;
  logic       halted_r, halted_nxt;

  logic [8:0] base_x, base_y, wx, wy;
  logic       halt_in, wrap, drop;

  always_comb begin
    base_x  = new_string ? {1'b0, start_x} : cursor_x_r;
    base_y  = new_string ? {1'b0, start_y} : cursor_y_r;
    halt_in = !new_string && halted_r;
    wrap    = ({1'b0, base_x} + 10'(GLYPH_W)) > WIDTH_LIM;
    wx      = wrap ? 9'd0 : base_x;
    wy      = wrap ? base_y + 9'(GLYPH_H) : base_y;
    drop    = ({1'b0, wy} + 10'(GLYPH_H)) > HEIGHT_LIM;

    place.keep = !halt_in && !drop;
    place.x    = wx[7:0];
    place.y    = wy[7:0];
    place.ch   = (char_code < CHAR_SPACE || char_code > CHAR_TILDE) ?
                 CHAR_SPACE[6:0] : char_code[6:0];

    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    halted_nxt   = halted_r;
    if (accept) begin
      if (halt_in) begin
        halted_nxt = 1'b1;
      end else if (drop) begin
        cursor_x_nxt = wx;
        cursor_y_nxt = wy;
        halted_nxt   = 1'b1;
      end else begin
        cursor_x_nxt = wx + 9'(GLYPH_W);
        cursor_y_nxt = wy;
        halted_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      halted_r   <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/trc_row_gen.sv
// pending-character slot and glyph row output register of the text character renderer
// depends on trc_pkg
`default_nettype none

module trc_row_gen import trc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_load,
  input  wire place_t      job,
  output logic             slot_free,
  input  wire logic [15:0] fg_color,
  input  wire logic [15:0] back_color,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_x,
  output logic [7:0]       out_y,
  output logic [3:0]       out_row,
  output logic [15:0]      out_pix [GLYPH_W],
  output logic             out_last
);

  logic        job_valid_r, job_valid_nxt;
  place_t      job_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [6:0]  ch_r, ch_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [15:0] pix_r [GLYPH_W];
  logic [15:0] pix_nxt [GLYPH_W];
  logic [7:0]  bits;
  logic        adv, more, job_take;

  always_comb begin
    adv      = !out_valid_r || out_ready;
    more     = out_valid_r && (row_r != ROW_LAST);
    job_take = adv && !more && job_valid_r;
    slot_free = !job_valid_r || job_take;

    job_valid_nxt = job_load ? 1'b1 : (job_take ? 1'b0 : job_valid_r);

    out_valid_nxt = out_valid_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    ch_nxt  = ch_r;
    row_nxt = row_r;
    if (adv) begin
      if (more) begin
        row_nxt = row_r + 4'd1;
      end else if (job_valid_r) begin
        out_valid_nxt = 1'b1;
        x_nxt   = job_r.x;
        y_nxt   = job_r.y;
        ch_nxt  = job_r.ch;
        row_nxt = 4'd0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    bits = font_row(ch_nxt, row_nxt);
    for (int i = 0; i < GLYPH_W; i++) begin
      pix_nxt[i] = bits[GLYPH_W - 1 - i] ? fg_color : back_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ch_r  <= ch_nxt;
    row_r <= row_nxt;
    pix_r <= pix_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_row   = row_r;
  assign out_pix   = pix_r;
  assign out_last  = (row_r == ROW_LAST);

endmodule

`default_nettype wire

// File: hdl/text_char_renderer.sv
// top level of the 8x16 bitmap text character renderer
// depends on trc_pkg, trc_cursor, trc_row_gen and text_char_renderer_macros.svh
//
//   channel   direction  handshake              payload
//   in_       in         in_valid / in_ready    char_code, new_string, start_x, start_y
//   out_      out        out_valid / out_ready  glyph_x, glyph_y, glyph_row, pixel_0..7, last_row
//   cfg_      in         cfg_we                 cfg_index, cfg_data
//
// a kept character gives 16 rows, one row per cycle from the row output register while out_ready
// is high; a dropped or halted character gives nothing
// one pending-character slot sits ahead of the row register, so the next item is taken
// while the current character is still being sent
// reset is synchronous, active low: cursor at (0,0), not halted, fg 0xffff, bg 0x0000
// out_ready low holds the current row; the slot then fills and in_ready drops
`default_nettype none

module text_char_renderer import trc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 160
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_new_string,
  input  wire logic [7:0]  in_start_x,
  input  wire logic [7:0]  in_start_y,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_glyph_x,
  output logic [7:0]       out_glyph_y,
  output logic [3:0]       out_glyph_row,
  output logic [15:0]      out_pixel_0,
  output logic [15:0]      out_pixel_1,
  output logic [15:0]      out_pixel_2,
  output logic [15:0]      out_pixel_3,
  output logic [15:0]      out_pixel_4,
  output logic [15:0]      out_pixel_5,
  output logic [15:0]      out_pixel_6,
  output logic [15:0]      out_pixel_7,
  output logic             out_last_row,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

`include "text_char_renderer_macros.svh"

  // register indexes
  localparam logic REG_FG_COLOR   = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;

  logic [15:0] fg_color_r, back_color_r;
  logic        in_accept, slot_free;
  place_t      place;
  logic [15:0] pix [GLYPH_W];

  // color registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r   <= 16'hffff;
      back_color_r <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG_COLOR:   fg_color_r   <= cfg_data;
        REG_BACK_COLOR: back_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = slot_free;
  assign in_accept = in_valid && in_ready;

  // placement is decided in the accept cycle, so the cursor is current for the next item
  trc_cursor #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .char_code  (in_char_code),
    .new_string (in_new_string),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .place      (place)
  );

  // only kept characters enter the slot
  trc_row_gen u_row_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (in_accept && place.keep),
    .job        (place),
    .slot_free  (slot_free),
    .fg_color   (fg_color_r),
    .back_color (back_color_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_glyph_x),
    .out_y      (out_glyph_y),
    .out_row    (out_glyph_row),
    .out_pix    (pix),
    .out_last   (out_last_row)
  );

  assign out_pixel_0 = pix[0];
  assign out_pixel_1 = pix[1];
  assign out_pixel_2 = pix[2];
  assign out_pixel_3 = pix[3];
  assign out_pixel_4 = pix[4];
  assign out_pixel_5 = pix[5];
  assign out_pixel_6 = pix[6];
  assign out_pixel_7 = pix[7];

  // rows of one character come out in order
  `TCR_ASSERT_NEXT(a_row_step, out_valid && out_ready && !out_last_row, out_valid && out_glyph_row == 4'($past(out_glyph_row) + 4'd1), "glyph row did not advance by one")
  // the character cell does not move between its rows
  `TCR_ASSERT_NEXT(a_cell_hold, out_valid && out_ready && !out_last_row, out_glyph_x == $past(out_glyph_x) && out_glyph_y == $past(out_glyph_y), "cell origin changed within a character")
  // a new character always starts at row 0
  `TCR_ASSERT_NEXT(a_row_restart, out_valid && out_ready && out_last_row, !out_valid || out_glyph_row == 4'd0, "character did not start at row 0")
  // input stalls only behind a character in progress
  `TCR_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input stalled with no rows pending")

endmodule

`default_nettype wire

// File: verif/tb_text_char_renderer.sv
// self-checking testbench for the 8x16 text character renderer
// holds its own cursor and font predictor in a small scoreboard class, drives the block
// with plain tasks; depends on trc_pkg and text_char_renderer
`default_nettype none

module tb_text_char_renderer;
  import trc_pkg::*;

  localparam int unsigned SCREEN_W = 128;
  localparam int unsigned SCREEN_H = 160;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // configuration register indexes
  localparam logic REG_FG_COLOR   = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;

  // one glyph, row 0 at the top
  typedef logic [0:15][7:0] glyph_t;

  // one row item as it leaves the block
  typedef struct packed {
    logic [7:0]        x;
    logic [7:0]        y;
    logic [3:0]        row;
    logic [0:7][15:0]  pix;
    logic              last;
  } glyph_row_t;

  // cursor, halt flag and colors tracked alongside the block; rows still owed are queued
  class glyph_scoreboard;
    logic [15:0]  fg;
    logic [15:0]  bg;
    logic [8:0]   cur_x;
    logic [8:0]   cur_y;
    bit           halted;
    glyph_row_t   rows_due[$];
    int unsigned  rows_seen;
    int unsigned  dropped;
    int unsigned  mismatches;

    function new();
      fg = 16'hffff;
      bg = 16'h0000;
      cur_x = '0;
      cur_y = '0;
      halted = 1'b0;
      rows_seen = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function void set_color(logic idx, logic [15:0] value);
      if (idx == REG_FG_COLOR) fg = value;
      else bg = value;
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    static function glyph_t font_glyph(logic [7:0] c);
      case (c)
        "%":     return 128'h0000464c_3a32160c_18342c5c_62000000;
        "-":     return 128'h00000000_0000003e_00000000_00000000;
        ".":     return 128'h00000000_00000000_00000000_0c0c0000;
        "0":     return 128'h00001c22_42424242_42424222_1c000000;
        "1":     return 128'h0000081c_08080808_08080808_1c000000;
        "2":     return 128'h00001c22_42020204_08102042_7e000000;
        "3":     return 128'h00001c22_4202021c_02024222_1c000000;
        "4":     return 128'h0000040c_14244444_7e040404_1e000000;
        "5":     return 128'h00007e40_40407c02_02024222_1c000000;
        "6":     return 128'h00001c22_40407c42_42424222_1c000000;
        "7":     return 128'h00007e42_02020404_08081010_10000000;
        "8":     return 128'h00001c22_42221c22_42424222_1c000000;
        "9":     return 128'h00001c22_4242423e_02024222_1c000000;
        ":":     return 128'h00000000_0c0c0000_00000c0c_00000000;
        "A":     return 128'h00001018_28284444_7c444444_44000000;
        "B":     return 128'h00007c22_22223c22_22222222_7c000000;
        "C":     return 128'h00003c42_42404040_40404242_3c000000;
        "M":     return 128'h00004262_72524a4a_42424242_42000000;
        "P":     return 128'h00007c22_22223c40_40404040_40000000;
        "R":     return 128'h00007c22_22223c28_24444444_44000000;
        "S":     return 128'h00003c42_42403c02_02024222_1c000000;
        "T":     return 128'h00007e18_18181818_18181818_18000000;
        "W":     return 128'h00004242_42424a4a_52526222_22000000;
        default: return '0;
      endcase
    endfunction

    // place one accepted character and queue the rows it owes
    function void note_char(logic [7:0] code, logic ns, logic [7:0] sx, logic [7:0] sy);
      glyph_t      g;
      glyph_row_t  r;
      logic [7:0]  c;
      if (ns) begin
        cur_x = {1'b0, sx};
        cur_y = {1'b0, sy};
        halted = 1'b0;
      end
      if (halted) begin
        dropped++;
        return;
      end
      if (int'(cur_x) + GLYPH_W > SCREEN_W) begin
        cur_x = '0;
        cur_y = cur_y + 9'd16;
      end
      if (int'(cur_y) + GLYPH_H > SCREEN_H) begin
        halted = 1'b1;
        dropped++;
        return;
      end
      c = (code < CHAR_SPACE || code > CHAR_TILDE) ? CHAR_SPACE : code;
      g = font_glyph(c);
      for (int row = 0; row < GLYPH_H; row++) begin
        r.x = cur_x[7:0];
        r.y = cur_y[7:0];
        r.row = 4'(row);
        for (int col = 0; col < GLYPH_W; col++)
          r.pix[col] = g[row][7 - col] ? fg : bg;
        r.last = (row == GLYPH_H - 1);
        rows_due.push_back(r);
      end
      cur_x = cur_x + 9'd8;
    endfunction

    function void flag(string what, glyph_row_t e, logic [15:0] ev, logic [15:0] av);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s at (%0d,%0d) row %0d: expected %h got %h",
                 what, e.x, e.y, e.row, ev, av);
    endfunction

    function void check_row(glyph_row_t a);
      glyph_row_t e;
      rows_seen++;
      if (rows_due.size() == 0) begin
        flag("row with nothing due", a, 16'h0, {12'h0, a.row});
        return;
      end
      e = rows_due.pop_front();
      if (a.x !== e.x) flag("glyph_x", e, 16'(e.x), 16'(a.x));
      if (a.y !== e.y) flag("glyph_y", e, 16'(e.y), 16'(a.y));
      if (a.row !== e.row) flag("glyph_row", e, 16'(e.row), 16'(a.row));
      for (int i = 0; i < GLYPH_W; i++)
        if (a.pix[i] !== e.pix[i]) flag($sformatf("pixel_%0d", i), e, e.pix[i], a.pix[i]);
      if (a.last !== e.last) flag("last_row", e, 16'(e.last), 16'(a.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = '0;
  logic        in_new_string = 1'b0;
  logic [7:0]  in_start_x = '0;
  logic [7:0]  in_start_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_glyph_x;
  logic [7:0]  out_glyph_y;
  logic [3:0]  out_glyph_row;
  logic [15:0] out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3;
  logic [15:0] out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7;
  logic        out_last_row;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_FG_COLOR;
  logic [15:0] cfg_data = '0;

  glyph_scoreboard sb = new();
  glyph_row_t      seen_row;
  bit              steady = 1'b0;   // no idling on either side while set
  int unsigned     cycles = 0;
  int unsigned     chars_sent = 0;
  int unsigned     strings_begun = 0;

  // every glyph character plus a space, used to build strings that mostly render ink
  string font_chars = " %-.:0123456789ABCMPRSTW";

  text_char_renderer #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_new_string (in_new_string),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_glyph_x   (out_glyph_x),
    .out_glyph_y   (out_glyph_y),
    .out_glyph_row (out_glyph_row),
    .out_pixel_0   (out_pixel_0),
    .out_pixel_1   (out_pixel_1),
    .out_pixel_2   (out_pixel_2),
    .out_pixel_3   (out_pixel_3),
    .out_pixel_4   (out_pixel_4),
    .out_pixel_5   (out_pixel_5),
    .out_pixel_6   (out_pixel_6),
    .out_pixel_7   (out_pixel_7),
    .out_last_row  (out_last_row),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // watchdog on a stuck handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still due", cycles, sb.pending());
      $display("tb_text_char_renderer: FAIL");
      $finish;
    end
  end

  // receiver back-pressure, about 22 stalls in a hundred outside the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 22);
  end

  assign seen_row = {out_glyph_x, out_glyph_y, out_glyph_row,
                     out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3,
                     out_pixel_4, out_pixel_5, out_pixel_6, out_pixel_7,
                     out_last_row};

  // every accepted row item goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_row(seen_row);
  end

  // present one character and hold it until the block takes it
  task automatic send_char(logic [7:0] code, logic ns, logic [7:0] sx, logic [7:0] sy);
    in_valid      <= 1'b1;
    in_char_code  <= code;
    in_new_string <= ns;
    in_start_x    <= sx;
    in_start_y    <= sy;
    do @(posedge clk); while (!in_ready);
    sb.note_char(code, ns, sx, sy);
    chars_sent++;
    if (ns) strings_begun++;
  endtask

  // sender gap at random
  task automatic maybe_pause();
    if (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // let every owed row drain, then idle before the next phase
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both colors on consecutive edges, only while the block is idle
  task automatic load_colors(logic [15:0] fg, logic [15:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG_COLOR;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= REG_BACK_COLOR;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_color(REG_FG_COLOR, fg);
    sb.set_color(REG_BACK_COLOR, bg);
  endtask

  task automatic pace_char(logic [7:0] code, logic ns, logic [7:0] sx, logic [7:0] sy);
    send_char(code, ns, sx, sy);
    maybe_pause();
  endtask

  task automatic run_directed();
    // no string start after reset: cursor runs from the origin, start fields ignored
    pace_char("0", 1'b0, 8'hff, 8'hff);
    pace_char("A", 1'b0, 8'h00, 8'h00);
    pace_char(8'h00, 1'b0, 8'h5a, 8'ha5);          // zero byte renders as space
    pace_char(8'hff, 1'b0, 8'ha5, 8'h5a);          // above tilde renders as space
    // last column that still fits, then a wrap to the next text line
    pace_char("%", 1'b1, 8'd120, 8'd0);
    pace_char("-", 1'b0, 8'd0, 8'd0);
    // start already past the right edge and then past the bottom: whole string dropped
    pace_char(".", 1'b1, 8'hff, 8'hff);
    pace_char(":", 1'b0, 8'd0, 8'd0);
    pace_char("1", 1'b0, 8'd0, 8'd0);
    // bottom line, then wrapping off the bottom halts the string
    pace_char(CHAR_TILDE, 1'b1, 8'd112, 8'd144);
    pace_char("2", 1'b0, 8'd0, 8'd0);
    pace_char("3", 1'b0, 8'd0, 8'd0);
    // a new string clears the halt; odd start position and the lettered glyphs
    pace_char("B", 1'b1, 8'd3, 8'd7);
    pace_char("C", 1'b0, 8'd0, 8'd0);
    pace_char("M", 1'b0, 8'd0, 8'd0);
    pace_char("P", 1'b0, 8'd0, 8'd0);
    pace_char("R", 1'b0, 8'd0, 8'd0);
    pace_char("S", 1'b0, 8'd0, 8'd0);
    pace_char("T", 1'b0, 8'd0, 8'd0);
    pace_char("W", 1'b0, 8'd0, 8'd0);
    pace_char(8'h7f, 1'b0, 8'd0, 8'd0);            // delete code, just past tilde
    pace_char(8'h1f, 1'b0, 8'd0, 8'd0);            // last control code
    // one column too far right wraps before the first character
    pace_char(CHAR_SPACE, 1'b1, 8'd121, 8'd0);
    send_char("9", 1'b0, 8'd0, 8'd0);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return font_chars[$urandom_range(font_chars.len() - 1)];
    if (roll < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed strings with random text; some noise and some off-screen starts
  task automatic run_random(int unsigned n_chars, bit calm);
    int unsigned done;
    int unsigned len;
    logic [7:0]  sx, sy;
    done = 0;
    while (done < n_chars) begin
      steady = calm && (done >= n_chars / 3) && (done < 2 * n_chars / 3);
      if ($urandom_range(99) < 15) begin
        pace_char(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                  8'($urandom_range(255)));
        done++;
      end else begin
        if ($urandom_range(99) < 80) begin
          sx = ($urandom_range(1)) ? 8'($urandom_range(15) * 8) : 8'($urandom_range(127));
          sy = 8'($urandom_range(144));
        end else begin
          sx = 8'($urandom_range(255));
          sy = 8'($urandom_range(255));
        end
        len = $urandom_range(1, 20);
        for (int k = 0; k < len && done < n_chars; k++) begin
          if (k == 0) pace_char(pick_char(), 1'b1, sx, sy);
          else pace_char(pick_char(), 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
          done++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // reset colors first
    run_directed();
    settle();
    // inverted extremes
    load_colors(16'h0000, 16'hffff);
    run_random(32, 1'b0);
    settle();
    // arbitrary colors, with a stretch of no idling in the middle
    load_colors(16'($urandom), 16'($urandom));
    run_random(32, 1'b1);
    settle();
    // back to the reset colors by explicit writes
    load_colors(16'hffff, 16'h0000);
    run_random(32, 1'b0);
    settle();
    $display("covered %0d characters in %0d strings under four color settings",
             chars_sent, strings_begun);
    $display("%0d rows checked, %0d characters dropped, %0d mismatches",
             sb.rows_seen, sb.dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_text_char_renderer: PASS");
    end else begin
      $display("tb_text_char_renderer: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
